@@ rtl/sst_pkg.sv @@
// Shared types, widths and codes of the sample statistics unit.
// Used by every module in rtl/; depends on nothing.
`default_nettype none

package sst_pkg;

   // Fixed field widths of the request and response transactions.
   localparam int SAMPLE_W = 16;
   localparam int COUNT_W  = 17;
   localparam int TOTAL_W  = 32;
   localparam int MEAN_W   = 24;
   localparam int VAR_W    = 31;
   localparam int ROOT_W   = 16;

   // Internal accumulator widths.
   localparam int SUM_W    = 33;
   localparam int SQ_W     = 31;
   localparam int SQSUM_W  = 47;
   localparam int MAG_W    = 32;
   localparam int DEN_W    = 34;
   localparam int REM_W    = 35;
   localparam int ALU_W    = 64;
   localparam int STEP_W   = 6;

   localparam int DEF_MAX_SAMPLES  = 65536;
   localparam int DEF_SAMPLE_WIDTH = 16;

   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_REPORT = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL_NS,
      ST_MUL_SQ,
      ST_MUL_NN,
      ST_DIV_VAR,
      ST_SQRT,
      ST_DIV_MEAN,
      ST_DONE
   } sst_state_type;

   typedef struct packed {
      sst_state_type state;
      logic          last;
      logic          busy;
      logic          done;
   } sst_ctrl_type;

   // Index of the final iteration of each sequenced phase.
   function automatic logic [STEP_W-1:0] last_step(sst_state_type st);
      logic [STEP_W-1:0] steps;
      case (st)
         ST_MUL_NS:   steps = STEP_W'(16);
         ST_MUL_SQ:   steps = STEP_W'(31);
         ST_MUL_NN:   steps = STEP_W'(16);
         ST_DIV_VAR:  steps = STEP_W'(63);
         ST_SQRT:     steps = STEP_W'(15);
         ST_DIV_MEAN: steps = STEP_W'(39);
         default:     steps = '0;
      endcase
      return steps;
   endfunction

endpackage

`default_nettype wire

@@ rtl/sst_alu.sv @@
// Shared 64-bit adder/subtractor used by every step of the report sequence.
// Depends on sst_pkg for its width.
`default_nettype none

module sst_alu (
   input  logic [sst_pkg::ALU_W-1:0] a_op,
   input  logic [sst_pkg::ALU_W-1:0] b_op,
   input  logic                      sub,
   output logic [sst_pkg::ALU_W-1:0] result,
   output logic                      carry
);
   import sst_pkg::*;

   localparam int FULL_W = ALU_W + 1;

   logic [ALU_W-1:0] b_eff;
   logic [ALU_W:0]   full_sum;

   assign b_eff    = sub ? ~b_op : b_op;
   assign full_sum = {1'b0, a_op} + {1'b0, b_eff} + FULL_W'(sub);

   // On a subtraction the carry out is set when a_op >= b_op.
   assign result = full_sum[ALU_W-1:0];
   assign carry  = full_sum[ALU_W];

endmodule

`default_nettype wire

@@ rtl/sst_accum.sv @@
// Running accumulators: count, sum, sum of squares, minimum, maximum, drop flag.
// Depends on sst_pkg; the square is registered before it enters the sum.
`default_nettype none

module sst_accum #(
   parameter int MAX_SAMPLES  = sst_pkg::DEF_MAX_SAMPLES,
   parameter int SAMPLE_WIDTH = sst_pkg::DEF_SAMPLE_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               add_valid,
   input  logic signed [sst_pkg::SAMPLE_W-1:0] sample,
   output logic [sst_pkg::COUNT_W-1:0]        count,
   output logic signed [sst_pkg::SUM_W-1:0]   sum,
   output logic [sst_pkg::SQSUM_W-1:0]        sqsum,
   output logic signed [sst_pkg::SAMPLE_W-1:0] smallest,
   output logic signed [sst_pkg::SAMPLE_W-1:0] largest,
   output logic                               dropped
);
   import sst_pkg::*;

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

   logic [CNT_W-1:0]          count_ff, count_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [SQSUM_W-1:0]        sqsum_ff, sqsum_in;
   logic signed [SAMPLE_W-1:0] min_ff, min_in;
   logic signed [SAMPLE_W-1:0] max_ff, max_in;
   logic                      dropped_ff, dropped_in;
   logic [SQ_W-1:0]           sq_ff, sq_in;
   logic                      sq_pend_ff, sq_pend_in;

   logic signed [SAMPLE_WIDTH-1:0] s_narrow;
   logic signed [SAMPLE_W-1:0]     s_ext;
   logic signed [2*SAMPLE_W-1:0]   product;
   logic                           full;
   logic                           first;

   assign s_narrow = sample[SAMPLE_WIDTH-1:0];
   assign s_ext    = SAMPLE_W'(s_narrow);
   assign product  = s_ext * s_ext;
   assign full     = (count_ff == CNT_W'(MAX_SAMPLES));
   assign first    = (count_ff == '0);

   always_comb begin
      count_in   = count_ff;
      sum_in     = sum_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      dropped_in = dropped_ff;
      sq_in      = product[SQ_W-1:0];
      sq_pend_in = 1'b0;
      sqsum_in   = sq_pend_ff ? sqsum_ff + SQSUM_W'(sq_ff) : sqsum_ff;
      if (add_valid) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            count_in   = count_ff + CNT_W'(1);
            sum_in     = sum_ff + SUM_W'(s_ext);
            sq_pend_in = 1'b1;
            if (first || s_ext < min_ff) begin
               min_in = s_ext;
            end
            if (first || s_ext > max_ff) begin
               max_in = s_ext;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         sum_ff     <= '0;
         sqsum_ff   <= '0;
         min_ff     <= '0;
         max_ff     <= '0;
         dropped_ff <= 1'b0;
         sq_pend_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         sum_ff     <= sum_in;
         sqsum_ff   <= sqsum_in;
         min_ff     <= min_in;
         max_ff     <= max_in;
         dropped_ff <= dropped_in;
         sq_pend_ff <= sq_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff <= sq_in;
   end

   assign count    = COUNT_W'(count_ff);
   assign sum      = sum_ff;
   assign sqsum    = sqsum_ff;
   assign smallest = min_ff;
   assign largest  = max_ff;
   assign dropped  = dropped_ff;

endmodule

`default_nettype wire

@@ rtl/sst_seq.sv @@
// Sequencer of the report computation: phase state and step counter.
// Depends on sst_pkg for the state type, control struct and step counts.
`default_nettype none

module sst_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  empty,
   input  logic                  take,
   output sst_pkg::sst_ctrl_type ctrl
);
   import sst_pkg::*;

   sst_state_type     state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              last;

   assign last = (cnt_ff == '0);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = empty ? ST_DONE : ST_MUL_NS;
         end
         ST_MUL_NS: begin
            if (last) begin
               state_in = ST_MUL_SQ;
            end
         end
         ST_MUL_SQ: begin
            if (last) begin
               state_in = ST_MUL_NN;
            end
         end
         ST_MUL_NN: begin
            if (last) begin
               state_in = ST_DIV_VAR;
            end
         end
         ST_DIV_VAR: begin
            if (last) begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (last) begin
               state_in = ST_DIV_MEAN;
            end
         end
         ST_DIV_MEAN: begin
            if (last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The counter reloads on every phase change and counts down otherwise.
   assign cnt_in = (state_in != state_ff) ? last_step(state_in) : cnt_ff - STEP_W'(1);

   always_comb begin
      ctrl.state = state_ff;
      ctrl.last  = last;
      ctrl.busy  = (state_ff != ST_IDLE);
      ctrl.done  = (state_ff == ST_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/sst_report.sv @@
// Report datapath: mean, variance and square root through one shared ALU.
// Depends on sst_pkg, sst_alu and sst_seq.
`default_nettype none

module sst_report (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             take,
   input  logic [sst_pkg::COUNT_W-1:0]      count,
   input  logic signed [sst_pkg::SUM_W-1:0] sum,
   input  logic [sst_pkg::SQSUM_W-1:0]      sqsum,
   output logic                             busy,
   output logic                             done,
   output logic [sst_pkg::MEAN_W-1:0]       mean,
   output logic [sst_pkg::VAR_W-1:0]        variance,
   output logic [sst_pkg::ROOT_W-1:0]       root
);
   import sst_pkg::*;

   sst_ctrl_type ctrl;

   logic [ALU_W-1:0]  acc_ff, acc_in;
   logic [ALU_W-1:0]  opnd_ff, opnd_in;
   logic [MAG_W-1:0]  mplr_ff, mplr_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [MEAN_W-1:0] mean_ff, mean_in;
   logic [VAR_W-1:0]  var_ff, var_in;
   logic [ROOT_W-1:0] root_ff, root_in;

   logic [ALU_W-1:0]  alu_a, alu_b, alu_result;
   logic              alu_sub, alu_carry;

   logic              empty;
   logic              negative;
   logic [SUM_W-1:0]  sum_neg;
   logic [MAG_W-1:0]  mag;
   logic [REM_W-1:0]  rem_var_sh, rem_mean_sh, rem_root_sh;
   logic [MEAN_W-1:0] quot_mean;
   logic [REM_W-1:0]  rem_mean_new;

   assign empty    = (count == '0);
   assign negative = sum[SUM_W-1];
   assign sum_neg  = ~sum + SUM_W'(1);
   assign mag      = negative ? sum_neg[MAG_W-1:0] : sum[MAG_W-1:0];

   // Partial remainders with the next dividend bit (or radicand pair) shifted in.
   assign rem_var_sh  = {rem_ff[REM_W-2:0], acc_ff[ALU_W-1]};
   assign rem_mean_sh = {rem_ff[REM_W-2:0], acc_ff[MAG_W+7]};
   assign rem_root_sh = {rem_ff[REM_W-3:0], opnd_ff[MAG_W-1:MAG_W-2]};

   assign quot_mean    = {acc_ff[MEAN_W-2:0], alu_carry};
   assign rem_mean_new = alu_carry ? alu_result[REM_W-1:0] : rem_mean_sh;

   sst_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .empty (empty),
      .take  (take),
      .ctrl  (ctrl)
   );

   sst_alu u_alu (
      .a_op   (alu_a),
      .b_op   (alu_b),
      .sub    (alu_sub),
      .result (alu_result),
      .carry  (alu_carry)
   );

   always_comb begin
      acc_in  = acc_ff;
      opnd_in = opnd_ff;
      mplr_in = mplr_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      mean_in = mean_ff;
      var_in  = var_ff;
      root_in = root_ff;
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      case (ctrl.state)
         ST_LOAD: begin
            acc_in  = '0;
            opnd_in = ALU_W'(sqsum);
            mplr_in = MAG_W'(count);
            den_in  = '0;
            rem_in  = '0;
            mean_in = '0;
            var_in  = '0;
            root_in = '0;
         end
         ST_MUL_NS: begin
            // Shift-and-add of count times sum of squares.
            alu_a   = acc_ff;
            alu_b   = opnd_ff;
            acc_in  = mplr_ff[0] ? alu_result : acc_ff;
            opnd_in = opnd_ff << 1;
            mplr_in = mplr_ff >> 1;
            if (ctrl.last) begin
               opnd_in = ALU_W'(mag);
               mplr_in = mag;
            end
         end
         ST_MUL_SQ: begin
            // Subtract the squared sum; the final difference is never negative.
            alu_a   = acc_ff;
            alu_b   = opnd_ff;
            alu_sub = 1'b1;
            acc_in  = mplr_ff[0] ? alu_result : acc_ff;
            opnd_in = opnd_ff << 1;
            mplr_in = mplr_ff >> 1;
            if (ctrl.last) begin
               opnd_in = ALU_W'(count);
               mplr_in = MAG_W'(count);
            end
         end
         ST_MUL_NN: begin
            alu_a   = ALU_W'(den_ff);
            alu_b   = opnd_ff;
            den_in  = mplr_ff[0] ? alu_result[DEN_W-1:0] : den_ff;
            opnd_in = opnd_ff << 1;
            mplr_in = mplr_ff >> 1;
         end
         ST_DIV_VAR: begin
            alu_a   = ALU_W'(rem_var_sh);
            alu_b   = ALU_W'(den_ff);
            alu_sub = 1'b1;
            rem_in  = alu_carry ? alu_result[REM_W-1:0] : rem_var_sh;
            acc_in  = {acc_ff[ALU_W-2:0], alu_carry};
            if (ctrl.last) begin
               var_in  = {acc_ff[VAR_W-2:0], alu_carry};
               opnd_in = ALU_W'({acc_ff[VAR_W-2:0], alu_carry});
               rem_in  = '0;
               root_in = '0;
            end
         end
         ST_SQRT: begin
            // One root bit per step: compare the remainder with 4*root+1.
            alu_a   = ALU_W'(rem_root_sh);
            alu_b   = ALU_W'({root_ff, 2'b01});
            alu_sub = 1'b1;
            rem_in  = alu_carry ? alu_result[REM_W-1:0] : rem_root_sh;
            root_in = {root_ff[ROOT_W-2:0], alu_carry};
            opnd_in = opnd_ff << 2;
            if (ctrl.last) begin
               acc_in = ALU_W'({mag, 8'h00});
               rem_in = '0;
            end
         end
         ST_DIV_MEAN: begin
            alu_a   = ALU_W'(rem_mean_sh);
            alu_b   = ALU_W'(count);
            alu_sub = 1'b1;
            rem_in  = rem_mean_new;
            acc_in  = {acc_ff[ALU_W-2:0], alu_carry};
            if (ctrl.last) begin
               // A negative mean rounds away from zero when a remainder is left.
               if (!negative) begin
                  mean_in = quot_mean;
               end else if (rem_mean_new != '0) begin
                  mean_in = ~quot_mean;
               end else begin
                  mean_in = ~quot_mean + MEAN_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      opnd_ff <= opnd_in;
      mplr_ff <= mplr_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      mean_ff <= mean_in;
      var_ff  <= var_in;
      root_ff <= root_in;
   end

   assign busy     = ctrl.busy;
   assign done     = ctrl.done;
   assign mean     = mean_ff;
   assign variance = var_ff;
   assign root     = root_ff;

endmodule

`default_nettype wire

@@ rtl/sample_statistics_unit.sv @@
// Sample statistics unit: an add transaction is taken every cycle, back to back,
// while no report is in progress. A report transaction runs three multiplies,
// a 64-step divide, a 16-step root and a 40-step divide (none when empty), all
// bit-serial through one shared 64-bit adder. req_stall is high meanwhile.
// Synchronous active-high reset clears all statistics and the drop flag.
`default_nettype none

module sample_statistics_unit #(
   parameter int MAX_SAMPLES  = sst_pkg::DEF_MAX_SAMPLES,
   parameter int SAMPLE_WIDTH = sst_pkg::DEF_SAMPLE_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic signed [sst_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_empty_res,
   output logic                                rsp_overflowed,
   output logic [sst_pkg::COUNT_W-1:0]         rsp_sample_count,
   output logic signed [sst_pkg::TOTAL_W-1:0]  rsp_total,
   output logic signed [sst_pkg::SAMPLE_W-1:0] rsp_smallest,
   output logic signed [sst_pkg::SAMPLE_W-1:0] rsp_largest,
   output logic signed [sst_pkg::MEAN_W-1:0]   rsp_mean_scaled,
   output logic [sst_pkg::VAR_W-1:0]           rsp_variance,
   output logic [sst_pkg::ROOT_W-1:0]          rsp_std_dev
);
   import sst_pkg::*;

   logic                       req_fire;
   logic                       add_valid;
   logic                       start;
   logic                       take;
   logic                       busy;
   logic                       done;
   logic                       load_rsp;

   logic [COUNT_W-1:0]         count;
   logic signed [SUM_W-1:0]    sum;
   logic [SQSUM_W-1:0]         sqsum;
   logic signed [SAMPLE_W-1:0] smallest;
   logic signed [SAMPLE_W-1:0] largest;
   logic                       dropped;
   logic [MEAN_W-1:0]          mean;
   logic [VAR_W-1:0]           variance;
   logic [ROOT_W-1:0]          root;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       empty_ff;
   logic                       overflowed_ff;
   logic [COUNT_W-1:0]         count_ff;
   logic signed [TOTAL_W-1:0]  total_ff;
   logic signed [SAMPLE_W-1:0] smallest_ff;
   logic signed [SAMPLE_W-1:0] largest_ff;
   logic [MEAN_W-1:0]          mean_ff;
   logic [VAR_W-1:0]           var_ff;
   logic [ROOT_W-1:0]          root_ff;

   assign req_stall = busy;
   assign req_fire  = req_valid && !req_stall;
   assign add_valid = req_fire && (req_command == CMD_ADD);
   assign start     = req_fire && (req_command == CMD_REPORT);

   // The result register is free when empty or drained in this cycle.
   assign take     = !rsp_valid_ff || !rsp_stall;
   assign load_rsp = done && take;

   sst_accum #(
      .MAX_SAMPLES  (MAX_SAMPLES),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .add_valid (add_valid),
      .sample    (req_sample),
      .count     (count),
      .sum       (sum),
      .sqsum     (sqsum),
      .smallest  (smallest),
      .largest   (largest),
      .dropped   (dropped)
   );

   sst_report u_report (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .take     (take),
      .count    (count),
      .sum      (sum),
      .sqsum    (sqsum),
      .busy     (busy),
      .done     (done),
      .mean     (mean),
      .variance (variance),
      .root     (root)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         empty_ff      <= (count == '0);
         overflowed_ff <= dropped;
         count_ff      <= count;
         total_ff      <= sum[TOTAL_W-1:0];
         smallest_ff   <= smallest;
         largest_ff    <= largest;
         mean_ff       <= mean;
         var_ff        <= variance;
         root_ff       <= root;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_empty_res    = empty_ff;
   assign rsp_overflowed   = overflowed_ff;
   assign rsp_sample_count = count_ff;
   assign rsp_total        = total_ff;
   assign rsp_smallest     = smallest_ff;
   assign rsp_largest      = largest_ff;
   assign rsp_mean_scaled  = mean_ff;
   assign rsp_variance     = var_ff;
   assign rsp_std_dev      = root_ff;

endmodule

`default_nettype wire
